[rtl/ictf_pkg.sv]
// ============================================================================
// ictf_pkg - shared types and constants for the complementary tilt filter
// Holds the angle format constants, the CORDIC arctangent table, the lane
// control struct and the configuration register indexes.
// ============================================================================
package ictf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int TABLE_LEN       = 24;
    localparam int RUN_STEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int STEP_W          = $clog2(TABLE_LEN + 1);

    // Register indexes
    localparam logic [2:0] REG_ACC_X_OFS  = 3'd0;
    localparam logic [2:0] REG_ACC_Y_OFS  = 3'd1;
    localparam logic [2:0] REG_ACC_Z_OFS  = 3'd2;
    localparam logic [2:0] REG_GYRO_X_OFS = 3'd3;
    localparam logic [2:0] REG_GYRO_Y_OFS = 3'd4;
    localparam logic [2:0] REG_GYRO_Z_OFS = 3'd5;
    localparam logic [2:0] REG_BLEND      = 3'd6;

    // Square root works on a 64-bit radicand: 32 result bits, one per cycle
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = 6;

    // Lane control from the sequencer
    typedef struct packed {
        logic start;     // load operands, begin the square root
        logic cordic;    // run one CORDIC step this cycle
    } lane_ctrl_t;

    // Lane status back to the sequencer
    typedef struct packed {
        logic sqrt_done;
        logic busy;
    } lane_stat_t;

    // atan(2^-i) in degrees, units of 1e-10 degree
    function automatic logic [63:0] atan_raw(input int idx);
        logic [63:0] raw;
        begin
            case (idx)
                0:       raw = 64'd450000000000;
                1:       raw = 64'd265650511771;
                2:       raw = 64'd140362434679;
                3:       raw = 64'd71250163489;
                4:       raw = 64'd35763343750;
                5:       raw = 64'd17899106082;
                6:       raw = 64'd8951737102;
                7:       raw = 64'd4476141709;
                8:       raw = 64'd2238105004;
                9:       raw = 64'd1119056771;
                10:      raw = 64'd559528919;
                11:      raw = 64'd279764526;
                12:      raw = 64'd139882271;
                13:      raw = 64'd69941137;
                14:      raw = 64'd34970569;
                15:      raw = 64'd17485284;
                16:      raw = 64'd8742642;
                17:      raw = 64'd4371321;
                18:      raw = 64'd2185661;
                19:      raw = 64'd1092830;
                20:      raw = 64'd546415;
                21:      raw = 64'd273208;
                22:      raw = 64'd136604;
                23:      raw = 64'd68302;
                default: raw = 64'd0;
            endcase
            atan_raw = raw;
        end
    endfunction

    typedef logic [TABLE_LEN-1:0][31:0] atan_tab_t;

    // Round every entry to ANGLE_FRAC_BITS fraction bits, once, at elaboration
    function automatic atan_tab_t build_atan_tab();
        atan_tab_t tab;
        logic [127:0] t;
        begin
            for (int i = 0; i < TABLE_LEN; i++)
            begin
                t      = ({64'd0, atan_raw(i)} << ANGLE_FRAC_BITS) + 128'd5000000000;
                tab[i] = 32'(t / 128'd10000000000);
            end
            build_atan_tab = tab;
        end
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();

    // atan(2^-i) in degrees with ANGLE_FRAC_BITS fraction bits, rounded
    function automatic logic [63:0] atan_entry(input logic [STEP_W-1:0] idx);
        begin
            atan_entry = (int'(idx) < TABLE_LEN) ? 64'(ATAN_TAB[idx]) : 64'd0;
        end
    endfunction

endpackage

[rtl/imu_complementary_tilt_filter.sv]
// ============================================================================
// imu_complementary_tilt_filter - six-axis complementary tilt filter
// Corrects a raw sample, integrates the gyro rates and blends pitch and roll
// with the accelerometer tilt from two parallel root/CORDIC lanes.
// ============================================================================
//  channel  dir  content
//  s_axis   in   tdata: acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, timestamp_ms
//  m_axis   out  tdata: pitch_angle, roll_angle, yaw_angle, elapsed_ms
//  cfg      in   wr_en, wr_index, wr_data (offsets, blend weight)
//
//  Each item runs the bit-serial square root and then the CORDIC steps in each
//  lane, then the product and blend steps, before the result is registered.
//  One item is in work at a time; the next is taken once the result sits in
//  the output register, even while that result waits for m_axis_tready.
//  Reset clears the filter state, previous tick and registers to defaults.
module imu_complementary_tilt_filter
    import ictf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, timestamp_ms
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // pitch_angle, roll_angle, yaw_angle, elapsed_ms
    input  logic         wr_en,
    input  logic [2:0]   wr_index,
    input  logic [16:0]  wr_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQRT   = 3'd1;
    localparam logic [2:0] ST_CORDIC = 3'd2;
    localparam logic [2:0] ST_PROD   = 3'd3;
    localparam logic [2:0] ST_BLEND  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [15:0] ofs_reg [6];
    logic [16:0] weight_reg;
    logic [2:0]  state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [31:0] prev_tick_reg;
    logic signed [16:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [15:0] dt_reg;
    logic        out_valid_reg;
    logic [111:0] out_data_reg;

    logic        in_fire;
    logic [31:0] now, diff;
    lane_ctrl_t  ctrl;
    lane_stat_t  stat_p, stat_r;
    logic signed [47:0] tilt_p, tilt_r;
    logic signed [31:0] pitch, roll, yaw;
    logic [2:0]  phase;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign now           = s_axis_tdata[127:96];
    assign diff          = now - prev_tick_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg[0] <= 16'd76;
            ofs_reg[1] <= 16'd76;
            ofs_reg[2] <= 16'hF768;
            ofs_reg[3] <= 16'd5;
            ofs_reg[4] <= 16'hFFFA;
            ofs_reg[5] <= 16'd1;
            weight_reg <= 17'd64225;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ACC_X_OFS:  ofs_reg[0] <= wr_data[15:0];
                REG_ACC_Y_OFS:  ofs_reg[1] <= wr_data[15:0];
                REG_ACC_Z_OFS:  ofs_reg[2] <= wr_data[15:0];
                REG_GYRO_X_OFS: ofs_reg[3] <= wr_data[15:0];
                REG_GYRO_Y_OFS: ofs_reg[4] <= wr_data[15:0];
                REG_GYRO_Z_OFS: ofs_reg[5] <= wr_data[15:0];
                REG_BLEND:      weight_reg <= wr_data;
                default:        ;
            endcase
        end
    end

    // Capture the corrected sample on acceptance
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ax_reg <= 17'($signed(s_axis_tdata[15:0]))  + 17'($signed(ofs_reg[0]));
            ay_reg <= 17'($signed(s_axis_tdata[31:16])) + 17'($signed(ofs_reg[1]));
            az_reg <= 17'($signed(s_axis_tdata[47:32])) + 17'($signed(ofs_reg[2]));
            gx_reg <= 17'($signed(s_axis_tdata[63:48])) + 17'($signed(ofs_reg[3]));
            gy_reg <= 17'($signed(s_axis_tdata[79:64])) + 17'($signed(ofs_reg[4]));
            gz_reg <= 17'($signed(s_axis_tdata[95:80])) + 17'($signed(ofs_reg[5]));
            dt_reg <= (diff > 32'd65535) ? 16'hFFFF : diff[15:0];
        end
    end

    // Sequence acceptance, root, CORDIC, product, blend and output
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ctrl.start  = 1'b0;
        ctrl.cordic = 1'b0;
        phase      = 3'b000;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (!stat_p.busy && !stat_p.sqrt_done && step_reg == '0)
                begin
                    ctrl.start = 1'b1;
                    step_next  = STEP_W'(1);
                end
                else if (stat_p.sqrt_done)
                begin
                    state_next = ST_CORDIC;
                    step_next  = '0;
                end
                phase[0] = 1'b1;
            end
            ST_CORDIC:
            begin
                ctrl.cordic = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == STEP_W'(RUN_STEPS - 1))
                begin
                    state_next = ST_PROD;
                    step_next  = '0;
                end
            end
            ST_PROD:
            begin
                phase[1]   = 1'b1;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                phase[2]   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            prev_tick_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_reg == ST_SQRT || state_reg == ST_CORDIC) ? step_next : '0;
            if (in_fire)
                prev_tick_reg <= now;
            if (state_reg == ST_OUT && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!out_valid_reg || m_axis_tready))
            out_data_reg <= {dt_reg, yaw, roll, pitch};
    end

    ictf_lane u_lane_pitch
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .step   (step_reg),
        .axis_a (ax_reg),
        .axis_b (ay_reg),
        .axis_c (az_reg),
        .stat   (stat_p),
        .tilt   (tilt_p)
    );

    ictf_lane u_lane_roll
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .step   (step_reg),
        .axis_a (ay_reg),
        .axis_b (ax_reg),
        .axis_c (az_reg),
        .stat   (stat_r),
        .tilt   (tilt_r)
    );

    ictf_merge u_merge
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .phase  (phase),
        .gx     (gx_reg),
        .gy     (gy_reg),
        .gz     (gz_reg),
        .dt     (dt_reg),
        .weight (weight_reg),
        .tilt_p (tilt_p),
        .tilt_r (tilt_r),
        .pitch  (pitch),
        .roll   (roll),
        .yaw    (yaw)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // Both lanes run in lock step
    assert property (@(posedge clk) disable iff (!rst_n) stat_p.busy == stat_r.busy)
        else $error("tilt lanes out of step");
    // An accepted item moves the sequencer into the root state
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> state_reg == ST_SQRT)
        else $error("accepted item did not start the root");
    // A waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
`endif

endmodule

[rtl/ictf_lane.sv]
// ============================================================================
// ictf_lane - one tilt lane: bit-serial square root and CORDIC vectoring
// Finds atan2(a, sqrt(b^2 + c^2)) in degrees for one axis, one root bit and
// then one CORDIC step per cycle.
// ============================================================================
module ictf_lane
    import ictf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctrl_t        ctrl,
    input  logic [STEP_W-1:0] step,
    input  logic signed [16:0] axis_a,
    input  logic signed [16:0] axis_b,
    input  logic signed [16:0] axis_c,
    output lane_stat_t        stat,
    output logic signed [47:0] tilt
);

    logic [63:0]        rem_reg, rem_next;
    logic [63:0]        root_reg, root_next;
    logic [63:0]        bit_reg, bit_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic               sqrt_busy_reg, sqrt_busy_next;
    logic               sqrt_done_reg, sqrt_done_next;
    logic signed [47:0] x_reg, x_next;
    logic signed [47:0] y_reg, y_next;
    logic signed [47:0] z_reg, z_next;
    logic               zero_reg, zero_next;

    logic [33:0]        sq_b, sq_c;
    logic [63:0]        trial;
    logic signed [47:0] xs, ys, ent;

    always_comb
    begin
        sq_b  = 34'($signed(axis_b) * $signed(axis_b));
        sq_c  = 34'($signed(axis_c) * $signed(axis_c));
        trial = root_reg + bit_reg;
        xs    = x_reg >>> step;
        ys    = y_reg >>> step;
        ent   = 48'(atan_entry(step));
    end

    // Load on start, advance the root one bit a cycle, then the CORDIC one step a cycle when asked
    always_comb
    begin
        rem_next       = rem_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        sqrt_busy_next = sqrt_busy_reg;
        sqrt_done_next = 1'b0;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zero_next      = zero_reg;
        if (ctrl.start)
        begin
            rem_next       = (64'(sq_b) + 64'(sq_c)) << 28;
            root_next      = '0;
            bit_next       = 64'd1 << 62;
            cnt_next       = '0;
            sqrt_busy_next = 1'b1;
            y_next         = 48'(axis_a) <<< 14;
            z_next         = '0;
            zero_next      = (axis_a == '0) && (axis_b == '0) && (axis_c == '0);
        end
        else if (sqrt_busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
            begin
                sqrt_busy_next = 1'b0;
                sqrt_done_next = 1'b1;
                x_next         = 48'(root_next);
            end
        end
        else if (ctrl.cordic)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ent;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ent;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqrt_busy_reg <= 1'b0;
            sqrt_done_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            sqrt_busy_reg <= sqrt_busy_next;
            sqrt_done_reg <= sqrt_done_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    assign stat.sqrt_done = sqrt_done_reg;
    assign stat.busy      = sqrt_busy_reg;
    assign tilt           = zero_reg ? '0 : z_reg;

endmodule

[rtl/ictf_merge.sv]
// ============================================================================
// ictf_merge - gyro integration and blend of the lane results
// Integrates the three gyro rates over the elapsed time, blends pitch and
// roll with the lane tilts, and holds the filter state.
// ============================================================================
module ictf_merge
    import ictf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        phase,     // one-hot: increment, product, blend
    input  logic signed [16:0] gx,
    input  logic signed [16:0] gy,
    input  logic signed [16:0] gz,
    input  logic [15:0]       dt,
    input  logic [16:0]       weight,
    input  logic signed [47:0] tilt_p,
    input  logic signed [47:0] tilt_r,
    output logic signed [31:0] pitch,
    output logic signed [31:0] roll,
    output logic signed [31:0] yaw
);

    logic signed [47:0] inc_p_reg, inc_r_reg, inc_z_reg;
    logic signed [95:0] prod_p_reg, prod_r_reg;
    logic signed [31:0] pitch_reg, pitch_next;
    logic signed [31:0] roll_reg, roll_next;
    logic [31:0]        yaw_reg, yaw_next;
    logic signed [17:0] r_s;

    function automatic logic signed [47:0] gyro_inc(input logic signed [16:0] g,
                                                     input logic [15:0] t);
        logic signed [33:0] p;
        logic [63:0] mag;
        begin
            p   = g * $signed({1'b0, t});
            mag = p[33] ? 64'(-p) : 64'(p);
            mag = ((mag << ANGLE_FRAC_BITS) + 64'd8192) >> 14;
            gyro_inc = p[33] ? -48'(mag) : 48'(mag);
        end
    endfunction

    function automatic logic signed [31:0] round_sat(input logic signed [95:0] v);
        logic [95:0] mag;
        logic signed [95:0] q;
        begin
            mag = v[95] ? 96'(-v) : 96'(v);
            mag = (mag + 96'd32768) >> 16;
            q   = v[95] ? -$signed(mag) : $signed(mag);
            if (q > 96'sd2147483647)
                round_sat = 32'sh7FFFFFFF;
            else if (q < -96'sd2147483648)
                round_sat = 32'sh80000000;
            else
                round_sat = 32'(q);
        end
    endfunction

    assign r_s = (weight > 17'd65536) ? 18'sd65536 : $signed({1'b0, weight});

    always_ff @(posedge clk)
    begin
        if (phase[0])
        begin
            inc_p_reg <= gyro_inc(gx, dt);
            inc_r_reg <= gyro_inc(gy, dt);
            inc_z_reg <= gyro_inc(gz, dt);
        end
        if (phase[1])
        begin
            prod_p_reg <= 96'(r_s) * 96'(48'(pitch_reg) + inc_p_reg)
                        + 96'(18'sd65536 - r_s) * 96'(tilt_p);
            prod_r_reg <= 96'(r_s) * 96'(48'(roll_reg) + inc_r_reg)
                        + 96'(18'sd65536 - r_s) * 96'(tilt_r);
        end
    end

    // Update the state in the blend phase
    always_comb
    begin
        pitch_next = pitch_reg;
        roll_next  = roll_reg;
        yaw_next   = yaw_reg;
        if (phase[2])
        begin
            pitch_next = round_sat(prod_p_reg);
            roll_next  = round_sat(prod_r_reg);
            yaw_next   = yaw_reg + inc_z_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= '0;
            roll_reg  <= '0;
            yaw_reg   <= '0;
        end
        else
        begin
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign pitch = pitch_reg;
    assign roll  = roll_reg;
    assign yaw   = $signed(yaw_reg);

endmodule

[verif/tb_imu_complementary_tilt_filter.sv]
// ============================================================================
// tb_imu_complementary_tilt_filter - self-checking bench for the tilt filter
// Drives raw six-axis samples under random bursts and gaps, stalls the result
// side on its own pattern, predicts every result with a bit-exact model of
// the offsets, gyro integration, square root, CORDIC tilt and blend, and
// compares each result field by field in order.
// ============================================================================
module tb_imu_complementary_tilt_filter
    import ictf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic signed [31:0] yaw;
        logic [15:0]        elapsed;
    } angles_t;

    // ------------------------------------------------------------------------
    // Tilt predictor and store of expected angles
    // ------------------------------------------------------------------------
    class tilt_scoreboard;
        logic [15:0] acc_ofs [3];
        logic [15:0] gyro_ofs [3];
        logic [16:0] weight;
        logic [31:0] last_tick;
        logic signed [31:0] pitch_st, roll_st;
        logic [31:0] yaw_st;
        angles_t pending [$];
        int errors;

        function void clear();
            acc_ofs = '{16'd76, 16'd76, -16'sd2200};
            gyro_ofs = '{16'd5, -16'sd6, 16'd1};
            weight = 17'd64225;
            last_tick = '0;
            pitch_st = '0;
            roll_st = '0;
            yaw_st = '0;
            pending.delete();
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [16:0] val);
            case (idx)
                REG_ACC_X_OFS:  acc_ofs[0] = val[15:0];
                REG_ACC_Y_OFS:  acc_ofs[1] = val[15:0];
                REG_ACC_Z_OFS:  acc_ofs[2] = val[15:0];
                REG_GYRO_X_OFS: gyro_ofs[0] = val[15:0];
                REG_GYRO_Y_OFS: gyro_ofs[1] = val[15:0];
                REG_GYRO_Z_OFS: gyro_ofs[2] = val[15:0];
                REG_BLEND:      weight = val;
                default: ;
            endcase
        endfunction

        // nearest, ties away from zero
        function longint round_div(longint v, int s);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (64'sd1 <<< (s - 1))) >>> s;
            return (v < 0) ? -m : m;
        endfunction

        function longint sqrt_floor(logic [63:0] n);
            logic [63:0] res, bit_w;
            res = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > n) bit_w >>= 2;
            while (bit_w != 0) begin
                if (n >= res + bit_w) begin
                    n -= res + bit_w;
                    res = (res >> 1) + bit_w;
                end
                else res >>= 1;
                bit_w >>= 2;
            end
            return longint'(res);
        endfunction

        function longint tilt(longint a, longint b, longint c);
            longint x, y, z, xs, ys;
            x = sqrt_floor(64'(b * b + c * c) << 28);
            y = a * 16384;
            z = 0;
            if (x == 0 && y == 0) return 0;
            for (int i = 0; i < RUN_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x += ys; y -= xs; z += longint'(atan_entry(STEP_W'(i)));
                end
                else begin
                    x -= ys; y += xs; z -= longint'(atan_entry(STEP_W'(i)));
                end
            end
            return z;
        endfunction

        function longint gyro_step(longint g, longint dt);
            longint p;
            p = g * dt;
            return round_div(p <<< ANGLE_FRAC_BITS, 14);
        endfunction

        function logic signed [31:0] mix(logic signed [31:0] prev, longint inc,
                                         longint tl, longint r);
            longint v;
            v = round_div(r * (longint'(prev) + inc) + (65536 - r) * tl, 16);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return 32'(v);
        endfunction

        // note an accepted sample and queue its expected angles
        function void note_sample(logic [127:0] d);
            longint a [3], g [3], r, dt;
            logic [31:0] diff;
            angles_t e;
            for (int i = 0; i < 3; i++) begin
                a[i] = longint'($signed(d[16*i +: 16])) + longint'($signed(acc_ofs[i]));
                g[i] = longint'($signed(d[48+16*i +: 16]))
                     + longint'($signed(gyro_ofs[i]));
            end
            diff = d[127:96] - last_tick;
            dt = (diff > 32'd65535) ? 65535 : longint'(diff);
            r = (weight > 17'd65536) ? 65536 : longint'(weight);
            last_tick = d[127:96];
            pitch_st = mix(pitch_st, gyro_step(g[0], dt), tilt(a[0], a[1], a[2]), r);
            roll_st = mix(roll_st, gyro_step(g[1], dt), tilt(a[1], a[0], a[2]), r);
            yaw_st = yaw_st + 32'(gyro_step(g[2], dt));
            e.pitch = pitch_st;
            e.roll = roll_st;
            e.yaw = yaw_st;
            e.elapsed = 16'(dt);
            pending.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [111:0] d);
            angles_t e;
            if (pending.size() == 0) begin
                report("unexpected item", d[31:0], 32'd0);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.pitch) report("pitch", d[31:0], e.pitch);
            if (d[63:32] !== e.roll) report("roll", d[63:32], e.roll);
            if (d[95:64] !== e.yaw) report("yaw", d[95:64], e.yaw);
            if (d[111:96] !== e.elapsed) report("elapsed", d[111:96], e.elapsed);
        endtask
    endclass

    logic clk, rst_n;
    logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [111:0] m_axis_tdata;
    logic wr_en;
    logic [2:0] wr_index;
    logic [16:0] wr_data;

    tilt_scoreboard sb;
    int hold_off;
    logic [31:0] tick;

    imu_complementary_tilt_filter dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("tb_imu_complementary_tilt_filter: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // offer one sample and hold it until taken; keep tvalid high if chained,
    // else drop it for one cycle
    task automatic send_sample(logic [127:0] d, bit keep);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_sample(d);
        if (!keep)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [15:0] rnd_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [127:0] make_sample(logic [15:0] ax, logic [15:0] ay,
                                                 logic [15:0] az, logic [15:0] gx,
                                                 logic [15:0] gy, logic [15:0] gz,
                                                 logic [31:0] ts);
        return {ts, gz, gy, gx, az, ay, ax};
    endfunction

    // random samples in bursts; timestamps mostly advance by up to 40 ms
    task automatic random_run(int count);
        int left, burst;
        logic [127:0] d;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            if (burst > left) burst = left;
            for (int i = 0; i < burst; i++)
            begin
                case ($urandom_range(0, 9))
                    0: tick = $urandom;
                    1: tick = tick + 32'($urandom_range(65536, 200000));
                    default: tick = tick + 32'($urandom_range(0, 40));
                endcase
                d = make_sample(rnd_axis(), rnd_axis(), rnd_axis(),
                                rnd_axis(), rnd_axis(), rnd_axis(), tick);
                send_sample(d, i != burst - 1);
            end
            left -= burst;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 60)) @(posedge clk);
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        hold_off = 0;
        tick = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        wr_en = 1'b0;
        wr_index = REG_ACC_X_OFS;
        wr_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first sample, extremes, zero tilt, lone axis, tick wrap
        send_sample(make_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd100000), 0);
        send_sample(make_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                16'h7fff, 32'd100010), 0);
        send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 32'hffff_fff0), 0);
        send_sample(make_sample(-16'sd76, -16'sd76, 16'd2200, 16'd0, 16'd0, 16'd0,
                                32'h0000_0005), 0);
        send_sample(make_sample(16'd1000, -16'sd76, 16'd2200, -16'sd5, 16'd6,
                                -16'sd1, 32'd5), 0);
        send_sample(make_sample(-16'sd1000, -16'sd76, 16'd2200, 16'h7fff, 16'h8000,
                                16'h7fff, 32'd70000), 0);
        send_sample(make_sample(-16'sd76, 16'd3000, 16'd2200, 16'd1, 16'd2, 16'd3,
                                32'd70001), 0);
        drain();

        // zero offsets, gyro only: drive pitch and roll to saturation
        for (int i = 0; i < 6; i++) write_reg(3'(i), 17'd0);
        write_reg(REG_BLEND, 17'h1ffff);
        for (int i = 0; i < 6; i++)
        begin
            tick = tick + 32'd65535;
            send_sample(make_sample(16'd0, 16'd0, 16'd0, 16'h7fff, 16'h8000, 16'h7fff,
                                    tick), 0);
        end
        send_sample(make_sample(16'd0, 16'd0, 16'd0, 16'h8000, 16'h7fff, 16'h8000,
                                tick + 1), 0);
        drain();

        // accelerometer only, extreme offsets
        write_reg(REG_BLEND, 17'd0);
        write_reg(REG_ACC_X_OFS, 17'h07fff);
        write_reg(REG_ACC_Y_OFS, 17'h08000);
        write_reg(REG_GYRO_Z_OFS, 17'h08000);
        random_run(40);

        // long result stall while the sender keeps offering
        hold_off = 400;
        random_run(30);
        drain();

        // default-like settings for the bulk of the run
        write_reg(REG_ACC_X_OFS, 17'd76);
        write_reg(REG_ACC_Y_OFS, 17'd76);
        write_reg(REG_ACC_Z_OFS, 17'h1f768);
        write_reg(REG_GYRO_X_OFS, 17'd5);
        write_reg(REG_GYRO_Y_OFS, 17'h1fffa);
        write_reg(REG_GYRO_Z_OFS, 17'd1);
        write_reg(REG_BLEND, 17'd64225);
        random_run(300);
        drain();

        // random settings, including full gyro weight
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 6; i++) write_reg(3'(i), 17'($urandom));
            write_reg(REG_BLEND, (k == 0) ? 17'd65536 : 17'($urandom_range(0, 65536)));
            random_run(90);
            drain();
        end

        if (sb.errors == 0)
            $display("tb_imu_complementary_tilt_filter: PASS");
        else
            $display("tb_imu_complementary_tilt_filter: FAIL");
        $finish;
    end

endmodule

[imu_complementary_tilt_filter.f]
rtl/ictf_pkg.sv
rtl/ictf_lane.sv
rtl/ictf_merge.sv
rtl/imu_complementary_tilt_filter.sv
verif/tb_imu_complementary_tilt_filter.sv
